// ===== design/nvr_pkg.sv =====
`timescale 1ns / 1ps

package nvr_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int FRAME_BYTES = (MAX_WIDTH * MAX_HEIGHT * 3) / 2;

  localparam int ADDR_W    = $clog2(FRAME_BYTES);
  localparam int IDX_W     = 19;
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 10;
  localparam int FRAC_W    = 16;
  localparam int COORD_W   = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int DVD_W     = DIM_W + FRAC_W;
  localparam int SCALE_W   = DVD_W - 1;
  localparam int POS_W     = SCALE_W + COORD_W;
  localparam int LO_W      = POS_W - FRAC_W;
  localparam int WGT_W     = FRAC_W + 1;
  localparam int HSUM_W    = PIX_W + FRAC_W;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CFG_DIV_STEPS = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] REQ_DIV_STEPS = CNT_W'(IDX_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CRN_LL = 2'd0,
    CRN_LH = 2'd1,
    CRN_HL = 2'd2,
    CRN_HH = 2'd3
  } corner_t;

  typedef struct packed {
    logic    mem_wr;
    logic    req_cap;
    logic    cdiv_start;
    logic    cdiv_y;
    logic    rdiv_start;
    logic    sel_cap;
    logic    ax_x;
    logic    ax_y;
    logic    row_cap;
    logic    rd_en;
    corner_t rd_corner;
    logic    cap_en;
    corner_t cap_corner;
    logic    hor;
    logic    ver;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero;
  } dp_status_t;

endpackage

// ===== design/nvr_if.sv =====
`timescale 1ns / 1ps

interface nvr_in_if import nvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] byte_index;
  logic [PIX_W-1:0] load_value;

  modport source (output valid, kind, byte_index, load_value, input ready);
  modport sink (input valid, kind, byte_index, load_value, output ready);
endinterface

interface nvr_out_if import nvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

// ===== design/nv12_bilinear_resize.sv =====
`timescale 1ns / 1ps

// NV12 bilinear resizer.
// in_ch carries items: kind 0 stores load_value at byte_index of the source
// frame, kind 1 asks for byte byte_index of the resized destination frame.
// out_ch returns one pixel_value per request and nothing for loads.
// The cfg port writes the four size registers (source width, source height,
// destination width, destination height), one per cycle, no wait.
// Loads can stream every cycle while in_ch is not held off by a request or a
// scale division. A request runs through the 19-step row/column divider and
// four serial reads of the single-port frame memory before its result appears
// on out_ch; a chroma byte outside the frame skips the reads and gives zero.
// The next item is taken after the result is registered.
// A size write queues a 26-step scale division for its axis (writes still
// pending share one); in_ch is not ready until the divisions are done.
// Reset sets all sizes to 512 and both scales to zero; the frame memory is
// not cleared and holds garbage until loaded.
// When out_ch stalls, the result waits in the output register; loads and
// one more request are accepted, then the block waits for the transfer.
module nv12_bilinear_resize import nvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nvr_in_if.sink               in_ch,
  nvr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  nvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .st        (st),
    .cmd       (cmd)
  );

  nvr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_byte_index (in_ch.byte_index),
    .in_load_value (in_ch.load_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_value   (out_ch.pixel_value)
  );

endmodule

// ===== design/nvr_div.sv =====
`timescale 1ns / 1ps

module nvr_div import nvr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] steps,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DIM_W-1:0] rem
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dq_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] dvs_r;
  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;
  logic             ge;

  // One restoring step per cycle; the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

// ===== design/nvr_dp.sv =====
`timescale 1ns / 1ps

module nvr_dp import nvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           st,
  input  logic [IDX_W-1:0]     in_byte_index,
  input  logic [PIX_W-1:0]     in_load_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic [PIX_W-1:0]     pixel_value
);

  localparam logic [DIM_W-1:0] MAX_W_V = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_V = DIM_W'(MAX_HEIGHT);

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [LO_W:0] v,
                                                     input logic [DIM_W-1:0] last);
    if (v > (LO_W + 1)'(last)) return last[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // Configuration and scale registers.
  logic [DIM_W-1:0]   src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SCALE_W-1:0] x_scale_r, y_scale_r;
  logic [ADDR_W-1:0]  luma_size_r, src_luma_r;
  logic [DIM_W-1:0]   src_clamp, dst_clamp;
  logic               cfg_mode_r, cfg_y_r, cfg_one_r;

  // Request registers.
  logic [IDX_W-1:0]   idx_r;
  logic               is_luma_r;
  logic               zero_r;
  logic               comp_r;
  logic [COORD_W-1:0] jx_r, iy_r;
  logic [COORD_W-1:0] xl_r, xh_r, yl_r, yh_r;
  logic [FRAC_W-1:0]  fx_r, fy_r;
  logic [ADDR_W-1:0]  rlo_r, rhi_r;
  logic [PIX_W-1:0]   m_r, n_r, p_r, q_r, mem_q_r;
  logic [HSUM_W-1:0]  top_r, bot_r;
  logic [PIX_W-1:0]   res_r, pixel_r;

  // Divider hookup.
  logic               div_start, div_done;
  logic [CNT_W-1:0]   div_steps;
  logic [DVD_W-1:0]   div_dvd, div_quot;
  logic [DIM_W-1:0]   div_dvs, div_rem;
  logic [IDX_W-1:0]   chroma_idx;
  logic               req_luma;

  assign src_clamp = (cfg_data < DIM_W'(2)) ? DIM_W'(2) :
                     (cfg_data > MAX_W_V) ? MAX_W_V : cfg_data;
  assign dst_clamp = (cfg_data < DIM_W'(1)) ? DIM_W'(1) :
                     (cfg_data > MAX_W_V) ? MAX_W_V : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= MAX_W_V;
      src_h_r   <= MAX_H_V;
      dst_w_r   <= MAX_W_V;
      dst_h_r   <= MAX_H_V;
      x_scale_r <= '0;
      y_scale_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SRC_W: src_w_r <= src_clamp;
          REG_SRC_H: src_h_r <= (cfg_data > MAX_H_V) ? MAX_H_V : src_clamp;
          REG_DST_W: dst_w_r <= dst_clamp;
          REG_DST_H: dst_h_r <= (cfg_data > MAX_H_V) ? MAX_H_V : dst_clamp;
          default: ;
        endcase
      end
      if (div_done && cfg_mode_r) begin
        if (cfg_y_r) y_scale_r <= cfg_one_r ? '0 : div_quot[SCALE_W-1:0];
        else         x_scale_r <= cfg_one_r ? '0 : div_quot[SCALE_W-1:0];
      end
    end
  end

  // Plane sizes follow the size registers in the cycle after; a write always
  // keeps the block busy far longer while its scale division runs.
  always_ff @(posedge clk) begin
    luma_size_r <= ADDR_W'(dst_w_r * dst_h_r);
    src_luma_r  <= ADDR_W'(src_w_r * src_h_r);
  end

  assign req_luma   = (idx_r < luma_size_r);
  assign chroma_idx = req_luma ? idx_r : (idx_r - luma_size_r);

  assign div_start = cmd.cdiv_start | cmd.rdiv_start;
  assign div_steps = cmd.cdiv_start ? CFG_DIV_STEPS : REQ_DIV_STEPS;
  assign div_dvd   = cmd.cdiv_start ? {(cmd.cdiv_y ? src_h_r : src_w_r), {FRAC_W{1'b0}}}
                                    : {chroma_idx, {(DVD_W - IDX_W){1'b0}}};
  assign div_dvs   = (cmd.cdiv_start && cmd.cdiv_y) ? dst_h_r : dst_w_r;

  nvr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= 1'b0;
    end else if (cmd.cdiv_start) begin
      cfg_mode_r <= 1'b1;
    end else if (cmd.rdiv_start) begin
      cfg_mode_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cdiv_start) begin
      cfg_y_r   <= cmd.cdiv_y;
      cfg_one_r <= ((cmd.cdiv_y ? dst_h_r : dst_w_r) <= DIM_W'(1));
    end
  end

  // Row and column of the destination byte.
  logic [IDX_W-1:0] q_row;
  logic [DIM_W-1:0] half_h, even_w;
  logic             chroma_out;

  assign q_row      = div_quot[IDX_W-1:0];
  assign half_h     = {1'b0, dst_h_r[DIM_W-1:1]};
  assign even_w     = {dst_w_r[DIM_W-1:1], 1'b0};
  assign chroma_out = (q_row >= IDX_W'(half_h)) || (div_rem >= even_w);

  always_ff @(posedge clk) begin
    if (cmd.req_cap) idx_r <= in_byte_index;
    if (cmd.rdiv_start) is_luma_r <= req_luma;
    if (cmd.sel_cap) begin
      iy_r <= q_row[COORD_W-1:0];
      if (is_luma_r) begin
        jx_r   <= div_rem[COORD_W-1:0];
        comp_r <= 1'b0;
        zero_r <= 1'b0;
      end else begin
        jx_r   <= COORD_W'(div_rem[DIM_W-1:1]);
        comp_r <= div_rem[0];
        zero_r <= chroma_out;
      end
    end
  end

  // Source positions: floor, ceil and fraction per axis.
  logic [POS_W-1:0] pos_x, pos_y;
  logic [LO_W:0]    lo_x, hi_x, lo_y, hi_y;
  logic [DIM_W-1:0] last_x, last_y;

  assign pos_x  = POS_W'(x_scale_r) * POS_W'(jx_r);
  assign pos_y  = POS_W'(y_scale_r) * POS_W'(iy_r);
  assign lo_x   = {1'b0, pos_x[POS_W-1:FRAC_W]};
  assign hi_x   = lo_x + (LO_W + 1)'(pos_x[FRAC_W-1:0] != '0);
  assign lo_y   = {1'b0, pos_y[POS_W-1:FRAC_W]};
  assign hi_y   = lo_y + (LO_W + 1)'(pos_y[FRAC_W-1:0] != '0);
  assign last_x = (is_luma_r ? src_w_r : {1'b0, src_w_r[DIM_W-1:1]}) - 1'b1;
  assign last_y = (is_luma_r ? src_h_r : {1'b0, src_h_r[DIM_W-1:1]}) - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.ax_x) begin
      xl_r <= clamp_coord(lo_x, last_x);
      xh_r <= clamp_coord(hi_x, last_x);
      fx_r <= pos_x[FRAC_W-1:0];
    end
    if (cmd.ax_y) begin
      yl_r <= clamp_coord(lo_y, last_y);
      yh_r <= clamp_coord(hi_y, last_y);
      fy_r <= pos_y[FRAC_W-1:0];
    end
  end

  // Row start addresses; chroma rows sit behind the luma plane.
  logic [ADDR_W-1:0] base;

  assign base = is_luma_r ? '0 : (src_luma_r + ADDR_W'(comp_r));

  always_ff @(posedge clk) begin
    if (cmd.row_cap) begin
      rlo_r <= base + ADDR_W'(ADDR_W'(yl_r) * ADDR_W'(src_w_r));
      rhi_r <= base + ADDR_W'(ADDR_W'(yh_r) * ADDR_W'(src_w_r));
    end
  end

  // Frame memory, one access per cycle.
  logic [PIX_W-1:0]   frame_mem [FRAME_BYTES];
  logic [COORD_W:0]   col_l, col_h;
  logic [ADDR_W-1:0]  rd_addr;

  assign col_l = is_luma_r ? {1'b0, xl_r} : {xl_r, 1'b0};
  assign col_h = is_luma_r ? {1'b0, xh_r} : {xh_r, 1'b0};

  always_comb begin
    unique case (cmd.rd_corner)
      CRN_LL:  rd_addr = rlo_r + ADDR_W'(col_l);
      CRN_LH:  rd_addr = rlo_r + ADDR_W'(col_h);
      CRN_HL:  rd_addr = rhi_r + ADDR_W'(col_l);
      CRN_HH:  rd_addr = rhi_r + ADDR_W'(col_h);
      default: rd_addr = rlo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      if (in_byte_index < ADDR_W'(FRAME_BYTES)) begin
        frame_mem[in_byte_index] <= in_load_value;
      end
    end else if (cmd.rd_en) begin
      mem_q_r <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_corner)
        CRN_LL:  m_r <= mem_q_r;
        CRN_LH:  n_r <= mem_q_r;
        CRN_HL:  p_r <= mem_q_r;
        default: q_r <= mem_q_r;
      endcase
    end
  end

  // Blend as a*(1-f) + b*f = (a << 16) + (b - a)*f, horizontal then vertical.
  logic signed [PIX_W:0]          hd_top, hd_bot;
  logic signed [HSUM_W+1:0]       hs_top, hs_bot;
  logic signed [HSUM_W:0]         vd;
  logic signed [HSUM_W+FRAC_W+1:0] vs;

  assign hd_top = $signed({1'b0, n_r}) - $signed({1'b0, m_r});
  assign hd_bot = $signed({1'b0, q_r}) - $signed({1'b0, p_r});
  assign hs_top = $signed({2'b00, m_r, {FRAC_W{1'b0}}}) + hd_top * $signed({1'b0, fx_r});
  assign hs_bot = $signed({2'b00, p_r, {FRAC_W{1'b0}}}) + hd_bot * $signed({1'b0, fx_r});
  assign vd     = $signed({1'b0, bot_r}) - $signed({1'b0, top_r});
  assign vs     = $signed({2'b00, top_r, {FRAC_W{1'b0}}}) + vd * $signed({1'b0, fy_r});

  always_ff @(posedge clk) begin
    if (cmd.hor) begin
      top_r <= hs_top[HSUM_W-1:0];
      bot_r <= hs_bot[HSUM_W-1:0];
    end
    if (cmd.ver) res_r <= vs[HSUM_W+FRAC_W-1:2*FRAC_W];
    if (cmd.out_load) pixel_r <= zero_r ? '0 : res_r;
  end

  assign pixel_value = pixel_r;
  assign st.div_done = div_done;
  assign st.zero     = zero_r;

endmodule

// ===== design/nvr_ctrl.sv =====
`timescale 1ns / 1ps

module nvr_ctrl import nvr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_status_t           st,
  output ctrl_cmd_t            cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CDIV = 16'h0002,
    S_PREP = 16'h0004,
    S_RDIV = 16'h0008,
    S_SEL  = 16'h0010,
    S_AXX  = 16'h0020,
    S_AXY  = 16'h0040,
    S_ROW  = 16'h0080,
    S_RD0  = 16'h0100,
    S_RD1  = 16'h0200,
    S_RD2  = 16'h0400,
    S_RD3  = 16'h0800,
    S_RDQ  = 16'h1000,
    S_HOR  = 16'h2000,
    S_VER  = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_x_r, pend_x_nxt;
  logic   pend_y_r, pend_y_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   cfg_x_hit, cfg_y_hit;

  assign cfg_x_hit = cfg_we && (cfg_reg_t'(cfg_index) == REG_SRC_W ||
                                cfg_reg_t'(cfg_index) == REG_DST_W);
  assign cfg_y_hit = cfg_we && (cfg_reg_t'(cfg_index) == REG_SRC_H ||
                                cfg_reg_t'(cfg_index) == REG_DST_H);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;

    unique case (state_r)
      S_IDLE: begin
        if (pend_x_r) begin
          cmd.cdiv_start = 1'b1;
          pend_x_nxt     = 1'b0;
          state_nxt      = S_CDIV;
        end else if (pend_y_r) begin
          cmd.cdiv_start = 1'b1;
          cmd.cdiv_y     = 1'b1;
          pend_y_nxt     = 1'b0;
          state_nxt      = S_CDIV;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            if (in_kind) begin
              cmd.req_cap = 1'b1;
              state_nxt   = S_PREP;
            end else begin
              cmd.mem_wr = 1'b1;
            end
          end
        end
      end
      S_CDIV: if (st.div_done) state_nxt = S_IDLE;
      S_PREP: begin
        cmd.rdiv_start = 1'b1;
        state_nxt      = S_RDIV;
      end
      S_RDIV: if (st.div_done) state_nxt = S_SEL;
      S_SEL: begin
        cmd.sel_cap = 1'b1;
        state_nxt   = S_AXX;
      end
      S_AXX: begin
        cmd.ax_x  = 1'b1;
        state_nxt = st.zero ? S_OUT : S_AXY;
      end
      S_AXY: begin
        cmd.ax_y  = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_cap = 1'b1;
        state_nxt   = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CRN_LL;
        state_nxt     = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_LH;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_LL;
        state_nxt      = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_HL;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_LH;
        state_nxt      = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CRN_HH;
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_HL;
        state_nxt      = S_RDQ;
      end
      S_RDQ: begin
        cmd.cap_en     = 1'b1;
        cmd.cap_corner = CRN_HH;
        state_nxt      = S_HOR;
      end
      S_HOR: begin
        cmd.hor   = 1'b1;
        state_nxt = S_VER;
      end
      S_VER: begin
        cmd.ver   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A size write always reruns the division for its axis.
    if (cfg_x_hit) pend_x_nxt = 1'b1;
    if (cfg_y_hit) pend_y_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_x_r    <= 1'b0;
      pend_y_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_x_r    <= pend_x_nxt;
      pend_y_r    <= pend_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_CDIV || state_r == S_RDIV))
    else $error("divider finished outside a divide state");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind) |=> (state_r == S_PREP))
    else $error("accepted request did not start");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted before scale update");
`endif

endmodule
